[sv/afnt_pkg.sv]
// Shared types, register codes and sine table generator for the AFSK tone modulator.
package afnt_pkg;

  localparam int unsigned STEP_W = 16;
  localparam int unsigned SAMPLE_W = 8;
  localparam int unsigned CFG_INDEX_W = 2;

  localparam logic [CFG_INDEX_W-1:0] REG_MARK_STEP = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_SPACE_STEP = 2'd1;

  localparam logic [STEP_W-1:0] MARK_STEP_RESET = 16'd8192;
  localparam logic [STEP_W-1:0] SPACE_STEP_RESET = 16'd15019;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
  localparam longint unsigned Q30_ONE = 64'd1 << 30;

  // One classified frame bit: tone already resolved by the front end.
  typedef struct packed {
    logic tone_is_space;
    logic first_bit;
    logic last_bit;
  } afnt_bit_t;

  // Restoring long division for the table build; evaluated at elaboration only.
  function automatic longint unsigned udiv64(input longint unsigned num,
                                             input longint unsigned den);
    longint unsigned quo;
    longint unsigned rem;
    quo = 64'd0;
    rem = 64'd0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[62:0], num[i]};
      if (rem >= den) begin
        rem = rem - den;
        quo[i] = 1'b1;
      end
    end
    return quo;
  endfunction

  // Table entry k of a 2^addr_bits sine table, floor(255*(0.5+0.45*sin)),
  // with the sine worked out in Q30 by quadrant folding and a Taylor series.
  // Evaluated at elaboration only.
  function automatic logic [SAMPLE_W-1:0] sine_entry(input int unsigned k,
                                                     input int unsigned addr_bits);
    int unsigned qb;
    int unsigned quarter;
    int unsigned q;
    int unsigned r;
    int unsigned j;
    longint unsigned x;
    longint unsigned term;
    longint unsigned sum;
    longint unsigned num;
    longint unsigned dv;
    qb = addr_bits - 2;
    quarter = 1 << qb;
    q = k >> qb;
    r = k & (quarter - 1);
    j = q[0] ? quarter - r : r;
    x = (HALF_PI_Q30 * longint'(j)) >> qb;
    term = x;
    sum = x;
    for (int unsigned n = 1; n <= 10; n++) begin
      term = (term * x) >> 30;
      term = (term * x) >> 30;
      dv = longint'(2 * n) * longint'(2 * n + 1);
      term = udiv64(term, dv);
      if (n[0]) begin
        sum = (sum > term) ? sum - term : 64'd0;
      end else begin
        sum = sum + term;
      end
    end
    if (sum > Q30_ONE) begin
      sum = Q30_ONE;
    end
    num = 64'd510 << 30;
    if (q >= 2) begin
      num = num - 64'd459 * sum;
    end else begin
      num = num + 64'd459 * sum;
    end
    return num[32 +: SAMPLE_W];
  endfunction

endpackage

[sv/afnt_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module afnt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[sv/afnt_front.sv]
// Front end: takes frame bits, applies first-bit reset and NRZI coding to the tone.
module afnt_front
  import afnt_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  logic      in_data_bit,
  input  logic      in_first_bit,
  input  logic      in_last_bit,
  input  logic      q_full,
  input  logic      table_ready,
  output logic      push,
  output afnt_bit_t push_data
);

  logic tone_r;
  logic tone_nxt;

  assign in_stall = q_full || !table_ready;
  assign push = in_valid && !in_stall;

  // first bit restarts on mark, then a zero bit toggles
  always_comb begin
    tone_nxt = in_first_bit ? 1'b0 : tone_r;
    tone_nxt = tone_nxt ^ !in_data_bit;
  end

  assign push_data = '{tone_is_space: tone_nxt,
                       first_bit: in_first_bit,
                       last_bit: in_last_bit};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tone_r <= 1'b0;
    end else if (push) begin
      tone_r <= tone_nxt;
    end
  end

endmodule

[sv/afnt_queue.sv]
// Short queue of classified bits between front end and sample engine.
module afnt_queue
  import afnt_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  afnt_bit_t push_data,
  output logic      full,
  input  logic      pop,
  output logic      head_valid,
  output afnt_bit_t head
);

  afnt_bit_t                entries_r [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0]   wr_ptr_r;
  logic [QUEUE_PTR_W-1:0]   rd_ptr_r;
  logic [QUEUE_CNT_W-1:0]   count_r;
  logic [QUEUE_CNT_W-1:0]   count_nxt;

  assign full = count_r == QUEUE_CNT_W'(QUEUE_DEPTH);
  assign head_valid = count_r != '0;
  assign head = entries_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      count_r <= count_nxt;
    end
  end

`ifndef SYNTHESIS
  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !push)
    else $error("queue written while full");
  a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> head_valid)
    else $error("queue popped while empty");
`endif

endmodule

[sv/afnt_back.sv]
// Sample engine: phase accumulator, sine table lookup and output register.
module afnt_back
  import afnt_pkg::*;
#(
  parameter int unsigned BIT_SAMPLES = 8,
  parameter int unsigned PHASE_BITS = 16,
  parameter int unsigned SINE_ADDR_BITS = 10
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [STEP_W-1:0]   mark_step,
  input  logic [STEP_W-1:0]   space_step,
  input  logic                head_valid,
  input  afnt_bit_t           head,
  output logic                pop,
  output logic                table_ready,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [SAMPLE_W-1:0] out_dac_sample,
  output logic                out_end_of_bit,
  output logic                out_frame_done
);

  localparam int unsigned TABLE_SIZE = 1 << SINE_ADDR_BITS;
  localparam int unsigned CNT_W = $clog2(BIT_SAMPLES);
  localparam int unsigned SUM_W = (PHASE_BITS > STEP_W) ? PHASE_BITS : STEP_W;

  typedef logic [SAMPLE_W-1:0] lut_t [TABLE_SIZE];

  function automatic lut_t build_lut();
    lut_t l;
    for (int unsigned k = 0; k < TABLE_SIZE; k++) begin
      l[k] = sine_entry(k, SINE_ADDR_BITS);
    end
    return l;
  endfunction

  localparam lut_t SINE_LUT = build_lut();

  logic                      fill_busy_r;
  logic [SINE_ADDR_BITS-1:0] fill_addr_r;
  logic [PHASE_BITS-1:0]     phase_r;
  logic [CNT_W-1:0]          cnt_r;
  logic                      out_valid_r;
  logic                      out_end_r;
  logic                      out_done_r;

  logic                      adv;
  logic                      issue;
  logic                      last_samp;
  logic [PHASE_BITS-1:0]     base;
  logic [STEP_W-1:0]         step;
  logic [SUM_W-1:0]          sum_wide;
  logic [PHASE_BITS-1:0]     phase_nxt;
  logic [SINE_ADDR_BITS-1:0] rd_addr;

  // the read data register doubles as the output sample register
  assign adv = !out_valid_r || !out_stall;
  assign issue = adv && head_valid && !fill_busy_r;
  assign last_samp = cnt_r == CNT_W'(BIT_SAMPLES - 1);
  assign pop = issue && last_samp;
  assign table_ready = !fill_busy_r;

  always_comb begin
    base = (cnt_r == '0 && head.first_bit) ? '0 : phase_r;
    step = head.tone_is_space ? space_step : mark_step;
    sum_wide = SUM_W'(base) + SUM_W'(step);
    phase_nxt = sum_wide[PHASE_BITS-1:0];
  end

  generate
    if (PHASE_BITS >= SINE_ADDR_BITS) begin : g_addr_top
      assign rd_addr = phase_nxt[PHASE_BITS-1 -: SINE_ADDR_BITS];
    end else begin : g_addr_shift
      assign rd_addr = {phase_nxt, {(SINE_ADDR_BITS - PHASE_BITS){1'b0}}};
    end
  endgenerate

  afnt_ram #(
    .WIDTH(SAMPLE_W),
    .DEPTH(TABLE_SIZE)
  ) u_sine_ram (
    .clk  (clk),
    .we   (fill_busy_r),
    .waddr(fill_addr_r),
    .wdata(SINE_LUT[fill_addr_r]),
    .re   (issue),
    .raddr(rd_addr),
    .rdata(out_dac_sample)
  );

  // load the sine table once after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_busy_r <= 1'b1;
      fill_addr_r <= '0;
    end else if (fill_busy_r) begin
      fill_addr_r <= fill_addr_r + 1'b1;
      if (fill_addr_r == SINE_ADDR_BITS'(TABLE_SIZE - 1)) begin
        fill_busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (issue) begin
        phase_r <= phase_nxt;
        cnt_r   <= last_samp ? '0 : cnt_r + 1'b1;
      end
      if (adv) begin
        out_valid_r <= issue;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      out_end_r  <= last_samp;
      out_done_r <= last_samp && head.last_bit;
    end
  end

  assign out_valid = out_valid_r;
  assign out_end_of_bit = out_end_r;
  assign out_frame_done = out_done_r;

`ifndef SYNTHESIS
  a_done_on_bit_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_done_r |-> out_end_r)
    else $error("frame done without end of bit");
  a_no_issue_in_fill: assert property (@(posedge clk) disable iff (!rst_n)
    fill_busy_r |-> !issue && !out_valid_r)
    else $error("sample issued during table load");
  a_cnt_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(BIT_SAMPLES - 1))
    else $error("sample counter out of range");
`endif

endmodule

[sv/afsk_nrzi_tone_modulator.sv]
// Top level of the NRZI AFSK tone modulator: step registers, front end, queue, sample engine.
//
// Each accepted frame bit yields BIT_SAMPLES unsigned DAC samples of a
// continuous-phase mark/space sine; a zero bit toggles the tone, a one keeps
// it, and a first bit restarts on mark at phase zero. The sample engine emits
// one sample per cycle while a bit is queued and out_stall is low; once the
// two-entry bit queue is full, a new bit is taken only as the engine pops the
// head bit after its last sample. On an idle block a bit's first sample passes
// through the queue and the registered table read before out_valid rises. After
// reset the sine table RAM is loaded with all 2^SINE_ADDR_BITS entries (1024 by
// default) and in_stall stays high until the load is done; step writes are taken throughout.
module afsk_nrzi_tone_modulator
  import afnt_pkg::*;
#(
  parameter int unsigned BIT_SAMPLES = 8,
  parameter int unsigned PHASE_BITS = 16,
  parameter int unsigned SINE_ADDR_BITS = 10
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [STEP_W-1:0]      cfg_wdata,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic                   in_data_bit,
  input  logic                   in_first_bit,
  input  logic                   in_last_bit,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [SAMPLE_W-1:0]    out_dac_sample,
  output logic                   out_end_of_bit,
  output logic                   out_frame_done
);

  logic [STEP_W-1:0] mark_step_r;
  logic [STEP_W-1:0] space_step_r;

  logic      push;
  afnt_bit_t push_data;
  logic      q_full;
  logic      pop;
  logic      head_valid;
  afnt_bit_t head;
  logic      table_ready;

  // unknown register indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mark_step_r  <= MARK_STEP_RESET;
      space_step_r <= SPACE_STEP_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MARK_STEP:  mark_step_r <= cfg_wdata;
        REG_SPACE_STEP: space_step_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  afnt_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data_bit (in_data_bit),
    .in_first_bit(in_first_bit),
    .in_last_bit (in_last_bit),
    .q_full      (q_full),
    .table_ready (table_ready),
    .push        (push),
    .push_data   (push_data)
  );

  afnt_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (pop),
    .head_valid(head_valid),
    .head      (head)
  );

  afnt_back #(
    .BIT_SAMPLES   (BIT_SAMPLES),
    .PHASE_BITS    (PHASE_BITS),
    .SINE_ADDR_BITS(SINE_ADDR_BITS)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .mark_step     (mark_step_r),
    .space_step    (space_step_r),
    .head_valid    (head_valid),
    .head          (head),
    .pop           (pop),
    .table_ready   (table_ready),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_dac_sample(out_dac_sample),
    .out_end_of_bit(out_end_of_bit),
    .out_frame_done(out_frame_done)
  );

endmodule

[tb/tb_afsk_nrzi_tone_modulator.sv]
// Self-checking testbench for the NRZI AFSK tone modulator, with a sample-accurate tone predictor.
import afnt_pkg::*;

localparam int unsigned TONE_SAMPLES = 8;
localparam int unsigned TONE_PHASE_W = 16;
localparam int unsigned TONE_ADDR_W = 10;
localparam int unsigned SINE_ENTRIES = 1 << TONE_ADDR_W;
localparam int unsigned SINE_QUARTER = SINE_ENTRIES / 4;
localparam longint unsigned QUARTER_TURN_Q30 = 64'd1686629713;

typedef struct {
  logic [SAMPLE_W-1:0] dac;
  logic                end_of_bit;
  logic                frame_done;
} tone_sample_t;

class afsk_tone_scoreboard;
  logic [SAMPLE_W-1:0]     sine_rom [SINE_ENTRIES];
  logic [STEP_W-1:0]       mark_step;
  logic [STEP_W-1:0]       space_step;
  logic [TONE_PHASE_W-1:0] phase;
  bit                      on_space;
  tone_sample_t            samples_due [$];
  int                      errors;

  function new();
    build_sine();
    mark_step = MARK_STEP_RESET;
    space_step = SPACE_STEP_RESET;
    phase = '0;
    on_space = 1'b0;
    errors = 0;
  endfunction

  // floor(255*(0.5+0.45*sin)) with a Q30 Taylor sine folded over quadrants
  function void build_sine();
    longint unsigned x;
    longint unsigned term;
    longint unsigned sum;
    longint unsigned num;
    int unsigned quad;
    int unsigned off;
    int unsigned j;
    for (int unsigned k = 0; k < SINE_ENTRIES; k++) begin
      quad = k / SINE_QUARTER;
      off = k % SINE_QUARTER;
      j = quad[0] ? SINE_QUARTER - off : off;
      x = (QUARTER_TURN_Q30 * longint'(j)) / SINE_QUARTER;
      term = x;
      sum = x;
      for (int unsigned n = 1; n <= 10; n++) begin
        term = (term * x) >> 30;
        term = (term * x) >> 30;
        term = term / (longint'(2 * n) * longint'(2 * n + 1));
        if (n[0]) begin
          sum = (sum > term) ? sum - term : 64'd0;
        end else begin
          sum = sum + term;
        end
      end
      if (sum > (64'd1 << 30)) begin
        sum = 64'd1 << 30;
      end
      num = 64'd510 << 30;
      if (quad >= 2) begin
        num = num - 64'd459 * sum;
      end else begin
        num = num + 64'd459 * sum;
      end
      sine_rom[k] = num[32 +: SAMPLE_W];
    end
  endfunction

  function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [STEP_W-1:0] val);
    if (idx == REG_MARK_STEP) begin
      mark_step = val;
    end else if (idx == REG_SPACE_STEP) begin
      space_step = val;
    end
  endfunction

  function void note_bit(logic data, logic first, logic last);
    logic [STEP_W-1:0] step_now;
    tone_sample_t s;
    if (first) begin
      phase = '0;
      on_space = 1'b0;
    end
    // NRZI: a zero flips the tone after any restart
    if (!data) begin
      on_space = !on_space;
    end
    step_now = on_space ? space_step : mark_step;
    for (int k = 0; k < TONE_SAMPLES; k++) begin
      phase = phase + step_now;
      s.dac = sine_rom[phase[TONE_PHASE_W-1 -: TONE_ADDR_W]];
      s.end_of_bit = (k == TONE_SAMPLES - 1);
      s.frame_done = s.end_of_bit && last;
      samples_due.push_back(s);
    end
  endfunction

  function int pending();
    return samples_due.size();
  endfunction

  task report(string msg);
    if (errors < 30) begin
      $display("mismatch at %0t: %s", $time, msg);
    end
    errors++;
  endtask

  task check_sample(logic [SAMPLE_W-1:0] dac, logic eob, logic done);
    tone_sample_t want;
    if (samples_due.size() == 0) begin
      report($sformatf("sample %0d with nothing pending", dac));
      return;
    end
    want = samples_due.pop_front();
    if (dac !== want.dac) begin
      report($sformatf("dac_sample got %0d want %0d", dac, want.dac));
    end
    if (eob !== want.end_of_bit) begin
      report($sformatf("end_of_bit got %b want %b", eob, want.end_of_bit));
    end
    if (done !== want.frame_done) begin
      report($sformatf("frame_done got %b want %b", done, want.frame_done));
    end
  endtask
endclass

module tb_afsk_nrzi_tone_modulator;

  localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED_A = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED_B = 2'd3;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 16;
  localparam int PHASE_ITEMS = 40;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [STEP_W-1:0]      cfg_wdata = '0;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  logic                   in_data_bit = 1'b0;
  logic                   in_first_bit = 1'b0;
  logic                   in_last_bit = 1'b0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic [SAMPLE_W-1:0]    out_dac_sample;
  logic                   out_end_of_bit;
  logic                   out_frame_done;

  afsk_tone_scoreboard sb;
  bit quiet = 1'b0;
  int out_run = 0;
  int idle_cycles = 0;

  afsk_nrzi_tone_modulator dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_data_bit   (in_data_bit),
    .in_first_bit  (in_first_bit),
    .in_last_bit   (in_last_bit),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_dac_sample(out_dac_sample),
    .out_end_of_bit(out_end_of_bit),
    .out_frame_done(out_frame_done)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Check each sample beat, then pick the next stall pattern
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && !out_stall) begin
      sb.check_sample(out_dac_sample, out_end_of_bit, out_frame_done);
    end
    if (quiet) begin
      out_stall <= 1'b0;
      out_run = 0;
    end else if (out_run > 0) begin
      out_run--;
    end else begin
      case ($urandom_range(0, 99)) inside
        [0:49]: begin
          out_stall <= 1'b0;
          out_run = $urandom_range(0, 7);
        end
        [50:89]: begin
          out_stall <= 1'b1;
          out_run = $urandom_range(0, 2);
        end
        default: begin
          out_stall <= 1'b1;
          out_run = $urandom_range(9, 39);
        end
      endcase
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic int pick_gap();
    int r;
    if (quiet) begin
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 55) begin
      return 0;
    end else if (r < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(10, 40);
  endfunction

  task automatic drive_bit(input logic data, input logic first, input logic last);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data_bit <= data;
    in_first_bit <= first;
    in_last_bit <= last;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    sb.note_bit(data, first, last);
  endtask

  task automatic write_cfg(input logic [CFG_INDEX_W-1:0] idx, input logic [STEP_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    sb.write_reg(idx, val);
  endtask

  // Hold off until every pending sample has come out and the engine settles
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic run_phase(input logic [STEP_W-1:0] mark, input logic [STEP_W-1:0] space,
                           input bit poke_unused, input bit calm, input int count);
    int sent;
    int len;
    wait_drained();
    write_cfg(REG_MARK_STEP, mark);
    write_cfg(REG_SPACE_STEP, space);
    // unused indexes must not disturb either step
    if (poke_unused) begin
      write_cfg(CFG_UNUSED_A, STEP_W'($urandom_range(0, 65535)));
      write_cfg(CFG_UNUSED_B, STEP_W'($urandom_range(0, 65535)));
    end
    cfg_we <= 1'b0;
    quiet = calm;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(0, 4) == 0) begin
        drive_bit($urandom_range(0, 1), $urandom_range(0, 1), $urandom_range(0, 1));
        sent++;
      end else begin
        len = $urandom_range(2, 12);
        for (int i = 0; i < len; i++) begin
          drive_bit($urandom_range(0, 1), i == 0, i == len - 1);
        end
        sent += len;
      end
    end
  endtask

  initial begin
    sb = new();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // reset steps: tone switching, restarts and frame ends
    drive_bit(1'b1, 1'b1, 1'b0);
    drive_bit(1'b1, 1'b0, 1'b0);
    drive_bit(1'b0, 1'b0, 1'b0);
    drive_bit(1'b1, 1'b0, 1'b0);
    drive_bit(1'b0, 1'b0, 1'b0);
    drive_bit(1'b0, 1'b1, 1'b0);
    drive_bit(1'b0, 1'b0, 1'b1);
    drive_bit(1'b1, 1'b0, 1'b0);
    drive_bit(1'b1, 1'b0, 1'b1);
    drive_bit(1'b1, 1'b1, 1'b1);
    drive_bit(1'b0, 1'b1, 1'b1);
    drive_bit(1'b0, 1'b0, 1'b0);

    run_phase(16'd0, 16'hFFFF, 1'b1, 1'b0, PHASE_ITEMS);
    run_phase(16'hFFFF, 16'd0, 1'b0, 1'b1, PHASE_ITEMS);
    run_phase(16'h8000, 16'd1, 1'b1, 1'b0, PHASE_ITEMS);
    run_phase(STEP_W'($urandom_range(0, 65535)), STEP_W'($urandom_range(0, 65535)), 1'b0,
              bit'($urandom_range(0, 1)), PHASE_ITEMS);
    run_phase(MARK_STEP_RESET, SPACE_STEP_RESET, 1'b0, 1'b0, PHASE_ITEMS);
    run_phase(STEP_W'($urandom_range(0, 65535)), STEP_W'($urandom_range(0, 65535)), 1'b1,
              1'b0, PHASE_ITEMS);

    wait_drained();
    if (sb.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

[files.f]
sv/afnt_pkg.sv
sv/afnt_ram.sv
sv/afnt_front.sv
sv/afnt_queue.sv
sv/afnt_back.sv
sv/afsk_nrzi_tone_modulator.sv
tb/tb_afsk_nrzi_tone_modulator.sv
